/* src/ppr_pkg.sv */
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int MAX_PATH_POINTS = 64;
    localparam int PTR_W = $clog2(MAX_PATH_POINTS);
    localparam int CNT_W = $clog2(MAX_PATH_POINTS + 1);

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_POINT   = 2'd0,
        MODE_OBJECT  = 2'd1,
        MODE_PREDICT = 2'd2,
        MODE_EVAL    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_WAITING = 3'd0,
        STAT_SHORT   = 3'd1,
        STAT_CLEAR   = 3'd2,
        STAT_WAIT    = 3'd3,
        STAT_REPLAN  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_LOOKAHEAD = 2'd0,
        REG_NEAR      = 2'd1,
        REG_BLOCK     = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_A,
        S_LD_B,
        S_DOT0,
        S_DOT1,
        S_LEN0,
        S_LEN1,
        S_LEN2,
        S_CMP,
        S_DIV,
        S_OFF0,
        S_OFF1,
        S_OFF2,
        S_HYP_A,
        S_HYP_B,
        S_HYP_C,
        S_SQRT,
        S_HYP_DONE,
        S_OBJ_END
    } state_t;

    // control between sequencer and root unit
    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m;
    endfunction

    function automatic logic signed [64:0] apply_sign(input logic [63:0] m, input logic neg);
        logic signed [64:0] r;
        r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return r;
    endfunction

endpackage

/* src/path_proximity_risk_monitor_core.sv */
`timescale 1ns / 1ps
// channel   signals                                   handshake
// -------   ---------------------------------------   ---------------------------
// input     mode x_coord y_coord new_path is_person   start && !busy
//           has_trajectory objects_valid time_ms
// result    status closest_distance closest_valid     result_valid, one cycle
//           occupancy_ms path_occupied_wait
// config    cfg_index cfg_data                        cfg_valid && cfg_ready
//
// evaluate beats keep the sequencer idle, the result shows in the next cycle
// a path point is bound by the square root unit
// an object or predicted point runs each stored segment through:
//   one shared 32x32 multiplier, a divider loop for a 16-bit quotient and the root unit
// reset clears path and frame state; the path memory is not cleared
// results cannot be stalled, cfg_ready is always high

module path_proximity_risk_monitor_core
    import ppr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic               new_path,
    input  logic               is_person,
    input  logic               has_trajectory,
    input  logic               objects_valid,
    input  logic [31:0]        time_ms,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic [31:0]        closest_distance,
    output logic               closest_valid,
    output logic [31:0]        occupancy_ms,
    output logic               path_occupied_wait,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    state_t state_reg, state_next;

    mode_t              mode_reg, mode_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic               person_reg, person_next, traj_reg, traj_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [31:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [31:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [32:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [31:0]        hdx_reg, hdx_next, hdy_reg, hdy_next;
    logic [31:0]        hux_reg, hux_next, huy_reg, huy_next;
    logic               sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic               sux_reg, sux_next, suy_reg, suy_next;
    logic               shift_reg, shift_next;
    logic signed [64:0] dot_reg, dot_next;
    logic [63:0]        len_reg, len_next;
    logic [63:0]        rem_reg, rem_next;
    logic [15:0]        t_reg, t_next;
    logic [3:0]         div_cnt_reg, div_cnt_next;
    logic signed [32:0] ha_reg, ha_next, hb_reg, hb_next;
    logic               mid_reg, mid_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        h_reg, h_next;
    logic [31:0]        best_reg, best_next;
    logic [CNT_W-1:0]   seg_reg, seg_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        acc_reg, acc_next;
    logic               reached_reg, reached_next;
    logic [31:0]        fc_reg, fc_next;
    logic               fcv_reg, fcv_next;
    logic               aff_reg, aff_next;
    logic               dyn_reg, dyn_next;
    logic               was_reg, was_next;
    logic [31:0]        occ_start_reg, occ_start_next;

    logic [31:0]        look_reg, look_next;
    logic [31:0]        near_reg, near_next;
    logic [31:0]        block_reg, block_next;

    logic               rv_reg, rv_next;
    status_t            status_reg, status_next;
    logic [31:0]        closest_reg, closest_next;
    logic               cvalid_reg, cvalid_next;
    logic [31:0]        occ_reg, occ_next;
    logic               wait_reg, wait_next;

    logic               accept;
    mode_t              in_mode;
    logic [CNT_W-1:0]   cnt_eff;
    logic               reached_eff;
    logic               pt_go, pt_first, obj_go;

    logic [31:0]        mul_a, mul_b;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr, ram_raddr;
    logic [31:0]        ram_wx, ram_wy, rdata_x, rdata_y;

    logic signed [32:0] dx_w, dy_w, ux_w, uy_w;
    logic [32:0]        mdx, mdy, mux_w, muy;
    logic               need_half, degen;
    logic [32:0]        ma, mb;
    logic               hyp_big;
    logic [64:0]        sq_sum;
    logic [64:0]        div_r2;
    logic               div_ge;
    logic signed [32:0] u_s, o_s;
    logic signed [33:0] diff;
    logic [31:0]        seg_d;
    logic               seg_more;
    logic [32:0]        acc_sum;

    sqrt_req_t          sq_req;
    sqrt_rsp_t          sq_rsp;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_mode   = mode_t'(mode);

    assign cnt_eff     = new_path ? '0 : count_reg;
    assign reached_eff = new_path ? 1'b0 : reached_reg;
    assign pt_go       = !reached_eff && (cnt_eff < CNT_W'(MAX_PATH_POINTS));
    assign pt_first    = (cnt_eff == '0);
    assign obj_go      = (count_reg >= CNT_W'(2)) &&
                         ((in_mode == MODE_OBJECT) || dyn_reg);

    // segment setup from the fresh end point
    always_comb
    begin
        dx_w  = {rdata_x[31], rdata_x} - {ax_reg[31], ax_reg};
        dy_w  = {rdata_y[31], rdata_y} - {ay_reg[31], ay_reg};
        ux_w  = {px_reg[31], px_reg} - {ax_reg[31], ax_reg};
        uy_w  = {py_reg[31], py_reg} - {ay_reg[31], ay_reg};
        mdx   = mag33(dx_w);
        mdy   = mag33(dy_w);
        mux_w = mag33(ux_w);
        muy   = mag33(uy_w);
        need_half = mdx[32] | mdx[31] | mdy[32] | mdy[31] |
                    mux_w[32] | mux_w[31] | muy[32] | muy[31];
        // raw squared length below five
        degen = (mdx <= 33'd2) && (mdy <= 33'd2) &&
                !((mdx == 33'd2) && (mdy != 33'd0)) &&
                !((mdy == 33'd2) && (mdx != 33'd0));
    end

    always_comb
    begin
        ma      = mag33(ha_reg);
        mb      = mag33(hb_reg);
        hyp_big = ma[32] | mb[32];
        sq_sum  = {1'b0, sq_reg} + {1'b0, prod_reg};
        div_r2  = {rem_reg, 1'b0};
        div_ge  = div_r2 >= {1'b0, len_reg};
        seg_d   = (shift_reg && mid_reg) ? (h_reg[31] ? SAT32 : {h_reg[30:0], 1'b0}) : h_reg;
        seg_more = (seg_reg + CNT_W'(1)) < count_reg;
        acc_sum = {1'b0, acc_reg} + {1'b0, h_reg};
    end

    // offset from the projection, one axis per state
    always_comb
    begin
        if (state_reg == S_OFF1)
        begin
            u_s = sux_reg ? -$signed({1'b0, hux_reg}) : $signed({1'b0, hux_reg});
            o_s = sdx_reg ? -$signed({1'b0, prod_reg[47:16]}) :
                            $signed({1'b0, prod_reg[47:16]});
        end
        else
        begin
            u_s = suy_reg ? -$signed({1'b0, huy_reg}) : $signed({1'b0, huy_reg});
            o_s = sdy_reg ? -$signed({1'b0, prod_reg[47:16]}) :
                            $signed({1'b0, prod_reg[47:16]});
        end
        diff = {u_s[32], u_s} - {o_s[32], o_s};
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DOT0:
            begin
                mul_a = hux_reg;
                mul_b = hdx_reg;
            end
            S_DOT1:
            begin
                mul_a = huy_reg;
                mul_b = hdy_reg;
            end
            S_LEN0:
            begin
                mul_a = hdx_reg;
                mul_b = hdx_reg;
            end
            S_LEN1:
            begin
                mul_a = hdy_reg;
                mul_b = hdy_reg;
            end
            S_OFF0:
            begin
                mul_a = {16'd0, t_reg};
                mul_b = hdx_reg;
            end
            S_OFF1:
            begin
                mul_a = {16'd0, t_reg};
                mul_b = hdy_reg;
            end
            S_HYP_A:
            begin
                mul_a = ma[31:0];
                mul_b = ma[31:0];
            end
            S_HYP_B:
            begin
                mul_a = mb[31:0];
                mul_b = mb[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (in_mode)
                        MODE_POINT:
                        begin
                            if (pt_go && !pt_first)
                            begin
                                state_next = S_HYP_A;
                            end
                        end
                        MODE_OBJECT, MODE_PREDICT:
                        begin
                            if (obj_go)
                            begin
                                state_next = S_LD_A;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LD_A:
            begin
                state_next = S_LD_B;
            end
            S_LD_B:
            begin
                state_next = degen ? S_HYP_A : S_DOT0;
            end
            S_DOT0:
            begin
                state_next = S_DOT1;
            end
            S_DOT1:
            begin
                state_next = S_LEN0;
            end
            S_LEN0:
            begin
                state_next = S_LEN1;
            end
            S_LEN1:
            begin
                state_next = S_LEN2;
            end
            S_LEN2:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ((dot_reg <= 0) || (dot_reg >= $signed({1'b0, len_reg})))
                begin
                    state_next = S_HYP_A;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = S_OFF0;
                end
            end
            S_OFF0:
            begin
                state_next = S_OFF1;
            end
            S_OFF1:
            begin
                state_next = S_OFF2;
            end
            S_OFF2:
            begin
                state_next = S_HYP_A;
            end
            S_HYP_A:
            begin
                state_next = hyp_big ? S_HYP_DONE : S_HYP_B;
            end
            S_HYP_B:
            begin
                state_next = S_HYP_C;
            end
            S_HYP_C:
            begin
                state_next = sq_sum[64] ? S_HYP_DONE : S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    state_next = S_HYP_DONE;
                end
            end
            S_HYP_DONE:
            begin
                if (mode_reg == MODE_POINT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = seg_more ? S_LD_B : S_OBJ_END;
                end
            end
            S_OBJ_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mode_next      = mode_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        person_next    = person_reg;
        traj_next      = traj_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        hdx_next       = hdx_reg;
        hdy_next       = hdy_reg;
        hux_next       = hux_reg;
        huy_next       = huy_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        sux_next       = sux_reg;
        suy_next       = suy_reg;
        shift_next     = shift_reg;
        dot_next       = dot_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        div_cnt_next   = div_cnt_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        mid_next       = mid_reg;
        sq_next        = sq_reg;
        h_next         = h_reg;
        best_next      = best_reg;
        seg_next       = seg_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        reached_next   = reached_reg;
        fc_next        = fc_reg;
        fcv_next       = fcv_reg;
        aff_next       = aff_reg;
        dyn_next       = dyn_reg;
        was_next       = was_reg;
        occ_start_next = occ_start_reg;
        rv_next        = 1'b0;
        status_next    = status_reg;
        closest_next   = closest_reg;
        cvalid_next    = cvalid_reg;
        occ_next       = occ_reg;
        wait_next      = wait_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[PTR_W-1:0];
        ram_wx         = px_reg;
        ram_wy         = py_reg;
        ram_raddr      = seg_reg[PTR_W-1:0];
        sq_req.start    = 1'b0;
        sq_req.radicand = sq_sum[63:0];

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (accept)
                begin
                    mode_next   = in_mode;
                    px_next     = x_coord;
                    py_next     = y_coord;
                    person_next = is_person;
                    traj_next   = has_trajectory;
                    unique case (in_mode)
                        MODE_POINT:
                        begin
                            if (new_path)
                            begin
                                count_next   = '0;
                                acc_next     = '0;
                                reached_next = 1'b0;
                            end
                            if (pt_go)
                            begin
                                if (pt_first)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = '0;
                                    ram_wx     = x_coord;
                                    ram_wy     = y_coord;
                                    count_next = CNT_W'(1);
                                    lx_next    = x_coord;
                                    ly_next    = y_coord;
                                end
                                else
                                begin
                                    ha_next  = {x_coord[31], x_coord} - {lx_reg[31], lx_reg};
                                    hb_next  = {y_coord[31], y_coord} - {ly_reg[31], ly_reg};
                                    mid_next = 1'b0;
                                end
                            end
                        end
                        MODE_OBJECT, MODE_PREDICT:
                        begin
                            if (in_mode == MODE_OBJECT)
                            begin
                                dyn_next = has_trajectory;
                            end
                            seg_next  = CNT_W'(1);
                            best_next = SAT32;
                        end
                        default:
                        begin
                            rv_next      = 1'b1;
                            closest_next = '0;
                            cvalid_next  = 1'b0;
                            occ_next     = '0;
                            wait_next    = 1'b0;
                            if ((count_reg == '0) || !objects_valid)
                            begin
                                status_next = STAT_WAITING;
                            end
                            else if (count_reg < CNT_W'(2))
                            begin
                                status_next = STAT_SHORT;
                            end
                            else
                            begin
                                closest_next = fcv_reg ? fc_reg : 32'd0;
                                cvalid_next  = fcv_reg;
                                if (aff_reg)
                                begin
                                    if (!was_reg)
                                    begin
                                        occ_start_next = time_ms;
                                    end
                                    was_next  = 1'b1;
                                    occ_next  = time_ms - (was_reg ? occ_start_reg : time_ms);
                                    wait_next = (time_ms - (was_reg ? occ_start_reg : time_ms))
                                                < block_reg;
                                    status_next = ((time_ms - (was_reg ? occ_start_reg : time_ms))
                                                   < block_reg) ? STAT_WAIT : STAT_REPLAN;
                                end
                                else
                                begin
                                    was_next    = 1'b0;
                                    status_next = STAT_CLEAR;
                                end
                            end
                            fc_next  = SAT32;
                            fcv_next = 1'b0;
                            aff_next = 1'b0;
                            dyn_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LD_A:
            begin
                ax_next = rdata_x;
                ay_next = rdata_y;
            end
            S_LD_B:
            begin
                bx_next    = rdata_x;
                by_next    = rdata_y;
                ux_next    = ux_w;
                uy_next    = uy_w;
                shift_next = need_half;
                hdx_next   = need_half ? mdx[32:1] : mdx[31:0];
                hdy_next   = need_half ? mdy[32:1] : mdy[31:0];
                hux_next   = need_half ? mux_w[32:1] : mux_w[31:0];
                huy_next   = need_half ? muy[32:1] : muy[31:0];
                sdx_next   = dx_w[32];
                sdy_next   = dy_w[32];
                sux_next   = ux_w[32];
                suy_next   = uy_w[32];
                ha_next    = ux_w;
                hb_next    = uy_w;
                mid_next   = 1'b0;
            end
            S_DOT1:
            begin
                dot_next = apply_sign(prod_reg, sux_reg ^ sdx_reg);
            end
            S_LEN0:
            begin
                dot_next = dot_reg + apply_sign(prod_reg, suy_reg ^ sdy_reg);
            end
            S_LEN1:
            begin
                len_next = prod_reg;
            end
            S_LEN2:
            begin
                len_next = len_reg + prod_reg;
            end
            S_CMP:
            begin
                rem_next     = dot_reg[63:0];
                t_next       = '0;
                div_cnt_next = '0;
                mid_next     = 1'b0;
                if (dot_reg <= 0)
                begin
                    ha_next = ux_reg;
                    hb_next = uy_reg;
                end
                else
                begin
                    ha_next = {px_reg[31], px_reg} - {bx_reg[31], bx_reg};
                    hb_next = {py_reg[31], py_reg} - {by_reg[31], by_reg};
                end
            end
            S_DIV:
            begin
                rem_next     = div_ge ? 64'(div_r2 - {1'b0, len_reg}) : div_r2[63:0];
                t_next       = {t_reg[14:0], div_ge};
                div_cnt_next = div_cnt_reg + 4'd1;
            end
            S_OFF1:
            begin
                ha_next = diff[32:0];
            end
            S_OFF2:
            begin
                hb_next  = diff[32:0];
                mid_next = 1'b1;
            end
            S_HYP_A:
            begin
                if (hyp_big)
                begin
                    h_next = SAT32;
                end
            end
            S_HYP_B:
            begin
                sq_next = prod_reg;
            end
            S_HYP_C:
            begin
                if (sq_sum[64])
                begin
                    h_next = SAT32;
                end
                else
                begin
                    sq_req.start = 1'b1;
                end
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    h_next = sq_rsp.root;
                end
            end
            S_HYP_DONE:
            begin
                if (mode_reg == MODE_POINT)
                begin
                    acc_next     = acc_sum[32] ? SAT32 : acc_sum[31:0];
                    reached_next = (acc_sum[32] ? SAT32 : acc_sum[31:0]) >= look_reg;
                    ram_we       = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                    lx_next      = px_reg;
                    ly_next      = py_reg;
                end
                else
                begin
                    if (seg_d < best_reg)
                    begin
                        best_next = seg_d;
                    end
                    // end point becomes the next start point
                    ax_next   = bx_reg;
                    ay_next   = by_reg;
                    seg_next  = seg_reg + CNT_W'(1);
                    ram_raddr = PTR_W'(seg_reg + CNT_W'(1));
                end
            end
            S_OBJ_END:
            begin
                if (mode_reg == MODE_OBJECT)
                begin
                    if (best_reg < fc_reg)
                    begin
                        fc_next = best_reg;
                    end
                    fcv_next = 1'b1;
                    if ((person_reg || traj_reg) && (best_reg < near_reg))
                    begin
                        aff_next = 1'b1;
                    end
                end
                else if (best_reg < near_reg)
                begin
                    aff_next = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        look_next  = look_reg;
        near_next  = near_reg;
        block_next = block_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOOKAHEAD: look_next  = cfg_data;
                REG_NEAR:      near_next  = cfg_data;
                REG_BLOCK:     block_next = cfg_data;
                default:       look_next  = look_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            acc_reg       <= '0;
            reached_reg   <= 1'b0;
            fc_reg        <= SAT32;
            fcv_reg       <= 1'b0;
            aff_reg       <= 1'b0;
            dyn_reg       <= 1'b0;
            was_reg       <= 1'b0;
            occ_start_reg <= '0;
            look_reg      <= 32'd196608;
            near_reg      <= 32'd98304;
            block_reg     <= 32'd5000;
            rv_reg        <= 1'b0;
            status_reg    <= STAT_WAITING;
            div_cnt_reg   <= '0;
            seg_reg       <= '0;
            mode_reg      <= MODE_POINT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            reached_reg   <= reached_next;
            fc_reg        <= fc_next;
            fcv_reg       <= fcv_next;
            aff_reg       <= aff_next;
            dyn_reg       <= dyn_next;
            was_reg       <= was_next;
            occ_start_reg <= occ_start_next;
            look_reg      <= look_next;
            near_reg      <= near_next;
            block_reg     <= block_next;
            rv_reg        <= rv_next;
            status_reg    <= status_next;
            div_cnt_reg   <= div_cnt_next;
            seg_reg       <= seg_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        person_reg  <= person_next;
        traj_reg    <= traj_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        lx_reg      <= lx_next;
        ly_reg      <= ly_next;
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        hdx_reg     <= hdx_next;
        hdy_reg     <= hdy_next;
        hux_reg     <= hux_next;
        huy_reg     <= huy_next;
        sdx_reg     <= sdx_next;
        sdy_reg     <= sdy_next;
        sux_reg     <= sux_next;
        suy_reg     <= suy_next;
        shift_reg   <= shift_next;
        dot_reg     <= dot_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        t_reg       <= t_next;
        ha_reg      <= ha_next;
        hb_reg      <= hb_next;
        mid_reg     <= mid_next;
        sq_reg      <= sq_next;
        prod_reg    <= prod_next;
        h_reg       <= h_next;
        best_reg    <= best_next;
        closest_reg <= closest_next;
        cvalid_reg  <= cvalid_next;
        occ_reg     <= occ_next;
        wait_reg    <= wait_next;
    end

    ppr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PATH_POINTS)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wx),
        .raddr (ram_raddr),
        .rdata (rdata_x)
    );

    ppr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PATH_POINTS)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wy),
        .raddr (ram_raddr),
        .rdata (rdata_y)
    );

    ppr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    assign result_valid       = rv_reg;
    assign status             = status_reg;
    assign closest_distance   = closest_reg;
    assign closest_valid      = cvalid_reg;
    assign occupancy_ms       = occ_reg;
    assign path_occupied_wait = wait_reg;

endmodule

/* src/ppr_ram.sv */
`timescale 1ns / 1ps

module ppr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ppr_isqrt.sv */
`timescale 1ns / 1ps

module ppr_isqrt
    import ppr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // one result bit per cycle, two radicand bits shifted in
    always_comb
    begin
        rem_sh    = {rem_reg[32:0], v_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            v_next    = {v_reg[61:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[30:0], ge};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

/* sim/path_proximity_risk_monitor_core_tb.sv */
`timescale 1ns / 1ps

module path_proximity_risk_monitor_core_tb;
    import ppr_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam logic [31:0] ONE_M = 32'h0001_0000;

    typedef struct {
        status_t     status;
        logic [31:0] closest;
        logic        cvalid;
        logic [31:0] occ;
        logic        wait_flag;
    } verdict_t;

    class risk_scoreboard;
        longint px[MAX_PATH_POINTS];
        longint py[MAX_PATH_POINTS];
        int unsigned n_pts;
        logic [31:0] accum;
        bit reached;
        logic [31:0] closest;
        bit closest_ok, affects, dynamic, occupied;
        logic [31:0] occ_start;
        logic [31:0] lookahead, near_thr, block_ms;
        verdict_t pending[$];
        int errors;

        function void reset_state();
            n_pts = 0; accum = 0; reached = 0;
            closest = SAT32; closest_ok = 0; affects = 0; dynamic = 0;
            occupied = 0; occ_start = 0;
            lookahead = 32'd196608; near_thr = 32'd98304; block_ms = 32'd5000;
            pending.delete(); errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_LOOKAHEAD: lookahead = data;
                REG_NEAR:      near_thr = data;
                REG_BLOCK:     block_ms = data;
                default: ;
            endcase
        endfunction

        function longint unsigned absv(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function logic [31:0] root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r[31:0];
        endfunction

        function logic [31:0] hypot_q(longint a, longint b);
            longint unsigned ma, mb, s1, sum;
            ma = absv(a);
            mb = absv(b);
            if (ma >= 64'h1_0000_0000 || mb >= 64'h1_0000_0000) return SAT32;
            s1 = ma * ma;
            sum = s1 + mb * mb;
            if (sum < s1) return SAT32;
            return root64(sum);
        endfunction

        function longint scaled(logic [31:0] t, longint d);
            longint unsigned m;
            m = (longint'(t) * absv(d)) >> 16;
            return d < 0 ? -longint'(m) : longint'(m);
        endfunction

        function logic [31:0] segment_gap(longint x, longint y, int ia);
            longint dx, dy, ux, uy, dot, len2;
            longint unsigned r, l;
            logic [31:0] t, h;
            int s;
            dx = px[ia+1] - px[ia]; dy = py[ia+1] - py[ia];
            ux = x - px[ia]; uy = y - py[ia];
            s = 0;
            if (absv(dx) < 3 && absv(dy) < 3 && dx*dx + dy*dy < 5) return hypot_q(ux, uy);
            while (absv(dx) >= 64'h8000_0000 || absv(dy) >= 64'h8000_0000 ||
                   absv(ux) >= 64'h8000_0000 || absv(uy) >= 64'h8000_0000)
            begin
                dx = dx / 2; dy = dy / 2; ux = ux / 2; uy = uy / 2;
                s++;
            end
            dot = ux*dx + uy*dy;
            len2 = dx*dx + dy*dy;
            if (dot <= 0) return hypot_q(x - px[ia], y - py[ia]);
            if (dot >= len2) return hypot_q(x - px[ia+1], y - py[ia+1]);
            r = dot; l = len2; t = 0;
            for (int i = 0; i < 16; i++)
            begin
                r = r << 1;
                t = t << 1;
                if (r >= l)
                begin
                    r = r - l;
                    t[0] = 1'b1;
                end
            end
            h = hypot_q(ux - scaled(t, dx), uy - scaled(t, dy));
            if (h > (SAT32 >> s)) return SAT32;
            return h << s;
        endfunction

        function logic [31:0] path_gap(longint x, longint y);
            logic [31:0] best, d;
            best = SAT32;
            for (int i = 1; i < n_pts; i++)
            begin
                d = segment_gap(x, y, i - 1);
                if (d < best) best = d;
            end
            return best;
        endfunction

        // predicted effect of one accepted beat
        function void note(mode_t m, logic signed [31:0] x, logic signed [31:0] y, bit np,
                           bit person, bit traj, bit objs, logic [31:0] now);
            logic [31:0] seg, d;
            logic [32:0] acc;
            verdict_t v;
            case (m)
                MODE_POINT:
                begin
                    if (np)
                    begin
                        n_pts = 0; accum = 0; reached = 0;
                    end
                    if (reached || n_pts >= MAX_PATH_POINTS) return;
                    if (n_pts > 0)
                    begin
                        seg = hypot_q(x - px[n_pts-1], y - py[n_pts-1]);
                        acc = accum + seg;
                        accum = acc[32] ? SAT32 : acc[31:0];
                        if (accum >= lookahead) reached = 1;
                    end
                    px[n_pts] = x; py[n_pts] = y;
                    n_pts++;
                end
                MODE_OBJECT:
                begin
                    dynamic = traj;
                    if (n_pts < 2) return;
                    d = path_gap(x, y);
                    if (d < closest) closest = d;
                    closest_ok = 1;
                    if ((person || traj) && d < near_thr) affects = 1;
                end
                MODE_PREDICT:
                begin
                    if (dynamic && n_pts >= 2 && path_gap(x, y) < near_thr) affects = 1;
                end
                default:
                begin
                    v = '{STAT_WAITING, 32'd0, 1'b0, 32'd0, 1'b0};
                    if (n_pts == 0 || !objs) v.status = STAT_WAITING;
                    else if (n_pts < 2) v.status = STAT_SHORT;
                    else
                    begin
                        if (closest_ok)
                        begin
                            v.closest = closest; v.cvalid = 1;
                        end
                        if (affects)
                        begin
                            if (!occupied)
                            begin
                                occ_start = now; occupied = 1;
                            end
                            v.occ = now - occ_start;
                            v.wait_flag = v.occ < block_ms;
                            v.status = v.wait_flag ? STAT_WAIT : STAT_REPLAN;
                        end
                        else
                        begin
                            occupied = 0;
                            v.status = STAT_CLEAR;
                        end
                    end
                    closest = SAT32; closest_ok = 0; affects = 0; dynamic = 0;
                    pending.insert(pending.size(), v);
                end
            endcase
        endfunction

        function void check(logic [2:0] st, logic [31:0] cd, logic cv, logic [31:0] oc,
                            logic w);
            verdict_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
            end
            if (cd !== e.closest)
            begin
                $display("%0t: closest_distance exp %h got %h", $time, e.closest, cd);
                errors++;
            end
            if (cv !== e.cvalid)
            begin
                $display("%0t: closest_valid exp %b got %b", $time, e.cvalid, cv); errors++;
            end
            if (oc !== e.occ)
            begin
                $display("%0t: occupancy_ms exp %0d got %0d", $time, e.occ, oc); errors++;
            end
            if (w !== e.wait_flag)
            begin
                $display("%0t: path_occupied_wait exp %b got %b", $time, e.wait_flag, w);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy;
    logic [1:0] mode;
    logic signed [31:0] x_coord, y_coord;
    logic new_path, is_person, has_trajectory, objects_valid;
    logic [31:0] time_ms;
    logic result_valid;
    logic [2:0] status;
    logic [31:0] closest_distance, occupancy_ms;
    logic closest_valid, path_occupied_wait;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    risk_scoreboard sb;
    longint cycles;
    int idle_pct;
    int unsigned beats;
    logic [31:0] now_ms;
    logic signed [31:0] cx, cy;

    path_proximity_risk_monitor_core DUT (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid)
            sb.check(status, closest_distance, closest_valid, occupancy_ms, path_occupied_wait);

    task automatic send(mode_t m, logic signed [31:0] x, logic signed [31:0] y, bit np,
                        bit person, bit traj, bit objs, logic [31:0] tm);
        @(negedge clk);
        mode = m; x_coord = x; y_coord = y; new_path = np; is_person = person;
        has_trajectory = traj; objects_valid = objs; time_ms = tm;
        start = 1'b1;
        do @(posedge clk); while (busy);
        sb.note(m, x, y, np, person, traj, objs, tm);
        beats++;
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
        while (busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] jitter(logic signed [31:0] c, int unsigned r);
        return c + $signed($urandom_range(2 * r)) - $signed(r);
    endfunction

    task automatic frame(int unsigned spread);
        int n;
        bit traj;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            traj = $urandom_range(1);
            send(MODE_OBJECT, jitter(cx, spread), jitter(cy, spread), $urandom_range(1),
                 $urandom_range(1), traj, $urandom_range(1), $urandom);
            repeat ($urandom_range(2))
                send(MODE_PREDICT, jitter(cx, spread), jitter(cy, spread), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom);
        end
        if ($urandom_range(9) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(2500);
        send(MODE_EVAL, $urandom, $urandom, $urandom_range(1), $urandom_range(1),
             $urandom_range(1), $urandom_range(7) != 0, now_ms);
    endtask

    task automatic random_phase(int pct, int unsigned items, int unsigned max_pts);
        int unsigned first;
        int unsigned n;
        idle_pct = pct;
        first = beats;
        while (beats - first < items)
        begin
            if ($urandom_range(99) < 12)
            begin
                // noise beat, fully random fields
                send(mode_t'($urandom_range(3)), $urandom, $urandom, $urandom_range(1),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom);
            end
            else if ($urandom_range(2) == 0)
            begin
                n = ($urandom_range(15) == 0) ? max_pts : $urandom_range(2, 6);
                cx = jitter(0, 32'h0004_0000);
                cy = jitter(0, 32'h0004_0000);
                for (int i = 0; i < n; i++)
                begin
                    send(MODE_POINT, cx, cy, i == 0, $urandom_range(1), $urandom_range(1),
                         $urandom_range(1), $urandom);
                    cx = jitter(cx, 2 * ONE_M);
                    cy = jitter(cy, 2 * ONE_M);
                end
            end
            else
            begin
                frame(3 * ONE_M);
            end
            if ($urandom_range(29) == 0) settle();
        end
        settle();
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        cycles = 0;
        idle_pct = 0;
        beats = 0;
        now_ms = 0;
        cx = 0; cy = 0;
        rst_n = 1'b0; start = 1'b0; mode = MODE_POINT; x_coord = 0; y_coord = 0;
        new_path = 0; is_person = 0; has_trajectory = 0; objects_valid = 0; time_ms = 0;
        cfg_valid = 1'b0; cfg_index = REG_LOOKAHEAD; cfg_data = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, empty path, short path, degenerate segments
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd100);
        send(MODE_OBJECT, ONE_M, 0, 0, 1, 1, 0, 0);
        send(MODE_PREDICT, 0, 0, 0, 0, 0, 0, 0);
        send(MODE_POINT, 0, 0, 1, 0, 0, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd200);
        send(MODE_POINT, 0, 0, 0, 0, 0, 0, 0);
        send(MODE_POINT, 2 * ONE_M, 0, 0, 0, 0, 0, 0);
        send(MODE_POINT, 2 * ONE_M, 1, 0, 0, 0, 0, 0);
        send(MODE_POINT, 4 * ONE_M, 0, 0, 0, 0, 0, 0);
        send(MODE_POINT, 5 * ONE_M, 0, 0, 0, 0, 0, 0);
        send(MODE_OBJECT, ONE_M, 32'sh8000, 0, 1, 0, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd1000);
        send(MODE_OBJECT, ONE_M, 20 * ONE_M, 0, 0, 1, 0, 0);
        send(MODE_PREDICT, 3 * ONE_M, 32'sh4000, 0, 0, 0, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd7000);
        send(MODE_OBJECT, 2 * ONE_M, 1, 0, 0, 0, 0, 0);
        send(MODE_PREDICT, 2 * ONE_M, 0, 0, 0, 0, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd8000);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 0, 32'd9000);
        // extreme coordinates force saturation and operand halving
        send(MODE_POINT, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1, 1, 32'hFFFF_FFFF);
        send(MODE_POINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
        send(MODE_OBJECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, 1, 0, 0);
        send(MODE_OBJECT, 32'sh0000_0001, 32'shFFFF_FFFF, 0, 1, 1, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'hFFFF_FF00);
        send(MODE_OBJECT, 0, 0, 0, 1, 0, 0, 0);
        send(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'd50);
        settle();

        write_cfg(REG_LOOKAHEAD, 32'd8 * ONE_M);
        write_cfg(REG_NEAR, 32'h0001_8000);
        write_cfg(REG_BLOCK, 32'd5000);
        random_phase(0, 28, 10);

        write_cfg(REG_LOOKAHEAD, 32'd0);
        write_cfg(REG_NEAR, 32'hFFFF_FFFF);
        write_cfg(REG_BLOCK, 32'd0);
        random_phase(56, 28, 8);

        write_cfg(REG_LOOKAHEAD, 32'hFFFF_FFFF);
        write_cfg(REG_NEAR, 32'd0);
        write_cfg(REG_BLOCK, 32'hFFFF_FFFF);
        random_phase(0, 28, 70);

        write_cfg(REG_UNUSED, $urandom);
        write_cfg(REG_LOOKAHEAD, 32'd6 * ONE_M);
        write_cfg(REG_NEAR, 32'd2 * ONE_M);
        write_cfg(REG_BLOCK, 32'd3000);
        random_phase(36, 28, 12);

        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d results never arrived", $time, sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/ppr_pkg.sv
src/ppr_ram.sv
src/ppr_isqrt.sv
src/path_proximity_risk_monitor_core.sv
sim/path_proximity_risk_monitor_core_tb.sv
